/* src/deq_pkg.sv */
// Shared types and constants for the searchable deque.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W     = 32;
    localparam int CMD_W      = 3;
    localparam int SIZE_W     = 5;
    localparam int STAT_W     = 2;
    localparam int IN_TDATA_W = 40;

    // Command codes carried in the input transfer
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_SEARCH     = 3'd4,
        CMD_CLEAR      = 3'd5,
        CMD_RESIZE     = 3'd6,
        CMD_DUMP       = 3'd7
    } cmd_t;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLIP  = 2'd3;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        COP_NOP        = 3'd0,
        COP_PUSH_BACK  = 3'd1,
        COP_PUSH_FRONT = 3'd2,
        COP_POP_FRONT  = 3'd3,
        COP_RESIZE     = 3'd4,
        COP_ROTATE     = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [WORD_W-1:0] value;
    } cell_ctrl_t;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_DUMP = 2'b10
    } state_t;

endpackage

/* src/deque_with_search_top.sv */
// Top level of the searchable deque: controller, result register and cell chain.
//
// Usage: commands arrive on the s_axis channel, one per transfer; results leave
// on the m_axis channel. Every command except dump gives one result with tlast
// high. Dump gives one result per stored element, front to back, tlast on the
// final one; a dump of an empty queue gives a single result with tuser low.
// Elements sit in a chain of DEPTH cells, the front in cell 0. Pushes, pops,
// resize and search all complete in the cycle the command is taken; search
// compares every cell in parallel. The result is registered in the output
// register in the cycle after the command; a non-empty dump first enters the
// dump state, and its first element is registered from there.
// Throughput: one command per cycle while the receiver takes results; a dump
// of a non-empty queue holds the input until its final element is emitted,
// as the chain rotates one place per element and returns to its original
// order at the end. An empty dump gives its single result like any command.
// When a result is waiting and m_axis_tready is low, the result register holds
// and s_axis_tready drops.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared.
`timescale 1ns / 1ps

module deque_with_search_top import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] cmd, [34:3] value, [39:35] resize target
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] found, [32:1] data, [34:33] status, [34+CNT_W:35] count, rest zero
    output logic [((35 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // [0] has_element
    output logic [0:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TDATA_W = ((35 + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Input field unpacking
    cmd_t              cmd;
    logic [WORD_W-1:0] value;
    logic [SIZE_W-1:0] size_req;

    assign cmd      = cmd_t'(s_axis_tdata[2:0]);
    assign value    = s_axis_tdata[34:3];
    assign size_req = s_axis_tdata[39:35];

    // Control and result registers
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  dump_idx_reg, dump_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              has_reg, has_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]  ocount_reg, ocount_next;
    logic              last_reg, last_next;

    cell_ctrl_t        ctrl;
    logic [CNT_W-1:0]  target;
    logic              clipped;
    logic              take_out;
    logic              s_fire;
    logic              search_hit;
    logic              dump_last;

    logic [WORD_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_match;

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] left_d;
        logic [WORD_W-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = value;
        end else begin : g_mid
            assign left_d = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign right_d = cell_data[g];
        end else begin : g_inner
            assign right_d = cell_data[g+1];
        end

        deq_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .target     (target),
            .left_data  (left_d),
            .right_data (right_d),
            .front_data (cell_data[0]),
            .data       (cell_data[g]),
            .match      (cell_match[g])
        );
    end

    assign search_hit = |cell_match;

    // Resize target, clipped to capacity
    assign clipped = (32'(size_req) > 32'(DEPTH));
    assign target  = clipped ? DEPTH_C : CNT_W'(size_req);

    // Handshake
    assign take_out      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_RUN) && take_out;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign dump_last     = (dump_idx_reg == count_reg - CNT_W'(1));

    // Command decode and result build
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        data_next      = data_reg;
        has_next       = has_reg;
        status_next    = status_reg;
        ocount_next    = ocount_reg;
        last_next      = last_reg;
        ctrl.op        = COP_NOP;
        ctrl.value     = value;

        if (out_valid_reg && m_axis_tready) out_valid_next = 1'b0;

        unique case (state_reg)
            S_RUN: begin
                if (s_fire) begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    data_next      = '0;
                    has_next       = 1'b0;
                    status_next    = STAT_OK;
                    last_next      = 1'b1;
                    unique case (cmd)
                        CMD_PUSH_BACK: begin
                            if (count_reg == DEPTH_C) begin
                                status_next = STAT_FULL;
                            end else begin
                                ctrl.op    = COP_PUSH_BACK;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (count_reg == DEPTH_C) begin
                                status_next = STAT_FULL;
                            end else begin
                                ctrl.op    = COP_PUSH_FRONT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (count_reg == '0) begin
                                status_next = STAT_EMPTY;
                            end else begin
                                ctrl.op    = COP_POP_FRONT;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: found_next = search_hit;
                        CMD_CLEAR:  count_next = '0;
                        CMD_RESIZE: begin
                            ctrl.op     = COP_RESIZE;
                            count_next  = target;
                            status_next = clipped ? STAT_CLIP : STAT_OK;
                        end
                        CMD_DUMP: begin
                            // empty queue keeps the single default result
                            if (count_reg != '0) begin
                                out_valid_next = 1'b0;
                                dump_idx_next  = '0;
                                state_next     = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                    ocount_next = count_next;
                end
            end
            S_DUMP: begin
                // emit cell 0, rotate the occupied run by one place
                if (take_out) begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    data_next      = cell_data[0];
                    has_next       = 1'b1;
                    status_next    = STAT_OK;
                    ocount_next    = count_reg;
                    last_next      = dump_last;
                    ctrl.op        = COP_ROTATE;
                    if (dump_last) begin
                        state_next = S_RUN;
                    end else begin
                        dump_idx_next = dump_idx_reg + CNT_W'(1);
                    end
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        found_reg  <= found_next;
        data_reg   <= data_next;
        has_reg    <= has_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    // Output packing
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = TDATA_W'({ocount_reg, status_reg, data_reg, found_reg});
    assign m_axis_tuser[0] = has_reg;
    assign m_axis_tlast    = last_reg;

endmodule

/* src/deq_cell.sv */
// One storage cell of the deque chain: holds the element at its position.
`timescale 1ns / 1ps

module deq_cell import deq_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]  count,
    input  logic [CNT_W-1:0]  target,
    input  logic [WORD_W-1:0] left_data,
    input  logic [WORD_W-1:0] right_data,
    input  logic [WORD_W-1:0] front_data,
    output logic [WORD_W-1:0] data,
    output logic              match
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              in_use;

    assign in_use = (IDX < count);

    // Next element for this position
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            COP_PUSH_BACK: begin
                if (IDX == count) data_next = ctrl.value;
            end
            COP_PUSH_FRONT: data_next = left_data;
            COP_POP_FRONT:  data_next = right_data;
            COP_RESIZE: begin
                if (!in_use && (IDX < target)) data_next = '0;
            end
            COP_ROTATE: begin
                // front element wraps to the back of the occupied run
                if (in_use) begin
                    data_next = (IDX == count - CNT_W'(1)) ? front_data : right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = in_use && (data_reg == ctrl.value);

endmodule

/* test/deque_with_search_top_test.sv */
// Self-checking testbench for the searchable deque: directed and random stream traffic against a predictor.
`timescale 1ns / 1ps

module deque_with_search_top_test;
    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = ((35 + CNT_W + 7) / 8) * 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int RAND_ITEMS = 255;

    // Tracks deque contents and the results each command must produce
    class deque_scoreboard;
        typedef struct packed {
            logic              found;
            logic [WORD_W-1:0] data;
            logic              has_element;
            logic [STAT_W-1:0] status;
            logic [CNT_W-1:0]  count;
            logic              last;
        } result_t;

        logic [WORD_W-1:0] slots [DEPTH];
        int unsigned       head;
        int unsigned       fill;
        result_t           expected_q [$];
        int                errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function void add_result(logic hit, logic [WORD_W-1:0] word, logic has,
                                 logic [STAT_W-1:0] stat, logic fin);
            result_t r;
            r.found       = hit;
            r.data        = word;
            r.has_element = has;
            r.status      = stat;
            r.count       = fill[CNT_W-1:0];
            r.last        = fin;
            expected_q.insert(expected_q.size(), r);
        endfunction

        // Apply one accepted command to the model and queue its results
        function void note_command(cmd_t op, logic [WORD_W-1:0] word, logic [SIZE_W-1:0] target);
            logic [STAT_W-1:0] stat;
            logic              hit;
            int unsigned       want;
            int unsigned       i;
            stat = STAT_OK;
            hit  = 1'b0;
            want = target;
            case (op)
                CMD_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        stat = STAT_FULL;
                    end else begin
                        slots[(head + fill) % DEPTH] = word;
                        fill++;
                    end
                end
                CMD_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        stat = STAT_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = word;
                        fill++;
                    end
                end
                CMD_POP_BACK: begin
                    if (fill == 0) stat = STAT_EMPTY;
                    else fill--;
                end
                CMD_POP_FRONT: begin
                    if (fill == 0) begin
                        stat = STAT_EMPTY;
                    end else begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                CMD_SEARCH: begin
                    for (i = 0; i < fill; i++)
                        if (slots[(head + i) % DEPTH] == word) hit = 1'b1;
                end
                CMD_CLEAR: begin
                    fill = 0;
                end
                CMD_RESIZE: begin
                    if (want > DEPTH) begin
                        want = DEPTH;
                        stat = STAT_CLIP;
                    end
                    for (i = fill; i < want; i++) slots[(head + i) % DEPTH] = '0;
                    fill = want;
                end
                default: begin
                    // dump: one result per element, or a single empty marker
                    if (fill == 0) begin
                        add_result(1'b0, '0, 1'b0, STAT_OK, 1'b1);
                    end else begin
                        for (i = 0; i < fill; i++)
                            add_result(1'b0, slots[(head + i) % DEPTH], 1'b1, STAT_OK,
                                       (i + 1 == fill));
                    end
                    return;
                end
            endcase
            add_result(hit, '0, 1'b0, stat, 1'b1);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one output transfer with the oldest expectation
        function void check_result(logic [OUT_W-1:0] tdata, logic tuser, logic tlast);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata=%h", tdata);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("found", want.found, tdata[0]);
            compare_field("data", $signed(want.data), $signed(tdata[32:1]));
            compare_field("has_element", want.has_element, tuser);
            compare_field("status", want.status, tdata[34:33]);
            compare_field("count", want.count, tdata[34+CNT_W:35]);
            compare_field("last", want.last, tlast);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    deque_scoreboard sb;
    bit              quiet;
    int              idle_cycles;

    deque_with_search_top #(.DEPTH(DEPTH)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones, none during quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0, 1: return WORD_W'($urandom_range(0, 7)) - 4;
            2: return $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // Present one command and hold it until the transfer completes
    task automatic send_command(cmd_t op, logic [WORD_W-1:0] word, logic [SIZE_W-1:0] target);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {target, word, op};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Result side backpressure
    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (!quiet && $urandom_range(0, 99) < 20)
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                            : $urandom_range(10, 30);
            end
        end
    end

    // Check results and record accepted commands at each rising edge
    initial begin : monitor
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            if (aresetn && s_axis_tvalid && s_axis_tready)
                sb.note_command(cmd_t'(s_axis_tdata[2:0]), s_axis_tdata[34:3],
                                s_axis_tdata[39:35]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : watchdog
        @(posedge aclk);
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int   pick;
        cmd_t op;
        sb            = new();
        quiet         = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty-queue corners, extremes, full and clipped cases
        send_command(CMD_DUMP, '0, '0);
        send_command(CMD_POP_BACK, '0, '0);
        send_command(CMD_POP_FRONT, '1, '1);
        send_command(CMD_SEARCH, '0, '0);
        send_command(CMD_PUSH_BACK, 32'h7fff_ffff, '0);
        send_command(CMD_PUSH_FRONT, 32'h8000_0000, '0);
        send_command(CMD_PUSH_BACK, 32'hffff_ffff, '1);
        send_command(CMD_SEARCH, 32'h8000_0000, '0);
        send_command(CMD_SEARCH, 32'h1234_5678, '0);
        send_command(CMD_DUMP, '0, '0);
        send_command(CMD_RESIZE, '0, 5'd31);
        send_command(CMD_PUSH_BACK, 32'h0000_0001, '0);
        send_command(CMD_PUSH_FRONT, 32'h0000_0002, '0);
        send_command(CMD_SEARCH, 32'h0000_0000, '0);
        send_command(CMD_DUMP, '0, '0);
        send_command(CMD_POP_FRONT, '0, '0);
        send_command(CMD_POP_BACK, '0, '0);
        send_command(CMD_RESIZE, '0, 5'd3);
        send_command(CMD_DUMP, '0, '0);
        send_command(CMD_RESIZE, '0, 5'd16);
        send_command(CMD_RESIZE, '0, 5'd17);
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_SEARCH, '0, '0);
        send_command(CMD_RESIZE, '0, 5'd0);
        send_command(CMD_DUMP, '0, '0);

        // Random: push-heavy mix so the queue keeps filling and draining
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 25)      op = CMD_PUSH_BACK;
            else if (pick < 45) op = CMD_PUSH_FRONT;
            else if (pick < 55) op = CMD_POP_BACK;
            else if (pick < 65) op = CMD_POP_FRONT;
            else if (pick < 79) op = CMD_SEARCH;
            else if (pick < 82) op = CMD_CLEAR;
            else if (pick < 91) op = CMD_RESIZE;
            else                op = CMD_DUMP;
            if (op == CMD_RESIZE)
                send_command(op, $urandom(), ($urandom_range(0, 7) == 0) ?
                             SIZE_W'($urandom_range(17, 31)) : SIZE_W'($urandom_range(0, 16)));
            else
                send_command(op, pick_word(), SIZE_W'($urandom_range(0, 31)));
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        quiet         = 1'b0;

        // Drain the remaining results, then allow for the output register
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
